@@ design/peul_pkg.sv @@
// ---------------------------------------------------------------------------
// peul_pkg
// Shared constants and types for the particle Euler integrator.
// ---------------------------------------------------------------------------
package peul_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Reset value of the step register, about 0.01 in Q16.16.
    localparam int DT_RESET = 655;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZMASS = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Per-axis control flags handed from the velocity to the position stages.
    typedef struct packed {
        logic sat;
        logic mzero;
    } t_ctrl;

endpackage

@@ design/peul_div.sv @@
// ---------------------------------------------------------------------------
// peul_div
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module peul_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 66
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0]  c_num;
        logic [NUM_W-1:0]  c_quo;
        logic [DEN_W-1:0]  c_rem;
        logic [DEN_W-1:0]  c_den;
        logic [SIDE_W-1:0] c_side;
        logic [DEN_W:0]    c_try;
        logic [DEN_W:0]    c_diff;
        logic              c_ge;

        if (k == 0) begin : g_first
            assign c_num  = i_num;
            assign c_quo  = '0;
            assign c_rem  = '0;
            assign c_den  = i_den;
            assign c_side = i_side;
        end else begin : g_next
            assign c_num  = r_num[k-1];
            assign c_quo  = r_quo[k-1];
            assign c_rem  = r_rem[k-1];
            assign c_den  = r_den[k-1];
            assign c_side = r_side[k-1];
        end

        // Bring down the next dividend bit and try a subtract.
        assign c_try  = {c_rem, c_num[NUM_W-1]};
        assign c_diff = c_try - {1'b0, c_den};
        assign c_ge   = (c_try >= {1'b0, c_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k]  <= c_num << 1;
                r_quo[k]  <= {c_quo[NUM_W-2:0], c_ge};
                r_rem[k]  <= c_ge ? c_diff[DEN_W-1:0] : c_try[DEN_W-1:0];
                r_den[k]  <= c_den;
                r_side[k] <= c_side;
            end
        end
    end

    assign o_quo  = r_quo[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

@@ design/peul_vel.sv @@
// ---------------------------------------------------------------------------
// peul_vel
// Velocity update: caps the quotient, zeroes the change for a zero mass,
// applies the force sign, adds and saturates. Two register stages.
// ---------------------------------------------------------------------------
module peul_vel
    import peul_pkg::*;
#(
    parameter int WORD_W = 32,
    parameter int QUO_W  = 49
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [QUO_W-1:0]         i_quo,
    input  logic                     i_fneg,
    input  logic                     i_mzero,
    input  logic signed [WORD_W-1:0] i_vel,
    input  logic signed [WORD_W-1:0] i_pos,
    output logic signed [WORD_W-1:0] o_vel,
    output logic signed [WORD_W-1:0] o_pos,
    output t_ctrl                    o_ctrl
);

    localparam logic [QUO_W-1:0] CAP = QUO_W'(1) << WORD_W;
    localparam logic signed [WORD_W+1:0] HI = {3'b000, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W+1:0] LO = {3'b111, {(WORD_W-1){1'b0}}};

    logic [WORD_W:0]            c_qcap;
    logic [WORD_W+1:0]          c_mag;
    logic signed [WORD_W+1:0]   n_dv;
    logic signed [WORD_W+1:0]   r_dv;
    logic signed [WORD_W-1:0]   r_vel;
    logic signed [WORD_W-1:0]   r_pos;
    logic                       r_mzero;
    logic signed [WORD_W+1:0]   c_sum;
    logic signed [WORD_W-1:0]   n_vn;
    logic                       n_sat;
    logic signed [WORD_W-1:0]   r_vn;
    logic signed [WORD_W-1:0]   r_pos2;
    t_ctrl                      r_ctrl;

    always_comb begin
        c_qcap = (i_quo > CAP) ? CAP[WORD_W:0] : i_quo[WORD_W:0];
        c_mag  = {1'b0, c_qcap};
        if (i_mzero) begin
            n_dv = '0;
        end else if (i_fneg) begin
            n_dv = -$signed(c_mag);
        end else begin
            n_dv = $signed(c_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv    <= n_dv;
            r_vel   <= i_vel;
            r_pos   <= i_pos;
            r_mzero <= i_mzero;
        end
    end

    always_comb begin
        c_sum = {{2{r_vel[WORD_W-1]}}, r_vel} + r_dv;
        n_sat = 1'b0;
        if (c_sum > HI) begin
            n_vn  = HI[WORD_W-1:0];
            n_sat = 1'b1;
        end else if (c_sum < LO) begin
            n_vn  = LO[WORD_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_vn = c_sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vn         <= n_vn;
            r_pos2       <= r_pos;
            r_ctrl.sat   <= n_sat;
            r_ctrl.mzero <= r_mzero;
        end
    end

    assign o_vel  = r_vn;
    assign o_pos  = r_pos2;
    assign o_ctrl = r_ctrl;

endmodule

@@ design/peul_pos.sv @@
// ---------------------------------------------------------------------------
// peul_pos
// Position update with the new velocity: magnitude, multiply by the step,
// rescale and sign, add and saturate. Four register stages.
// ---------------------------------------------------------------------------
module peul_pos
    import peul_pkg::*;
#(
    parameter int WORD_W = 32,
    parameter int FRAC_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [FRAC_W:0]          i_dt,
    input  logic signed [WORD_W-1:0] i_vel,
    input  logic signed [WORD_W-1:0] i_pos,
    input  t_ctrl                    i_ctrl,
    output logic signed [WORD_W-1:0] o_vel,
    output logic signed [WORD_W-1:0] o_pos,
    output t_ctrl                    o_ctrl
);

    localparam int PROD_W = WORD_W + FRAC_W + 1;
    localparam logic signed [WORD_W+1:0] HI = {3'b000, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W+1:0] LO = {3'b111, {(WORD_W-1){1'b0}}};

    // Stage 1: magnitude of the velocity.
    logic [WORD_W-1:0]        r1_mag;
    logic                     r1_neg;
    logic signed [WORD_W-1:0] r1_vel, r1_pos;
    t_ctrl                    r1_ctrl;
    // Stage 2: product.
    logic [PROD_W-1:0]        r2_prod;
    logic                     r2_neg;
    logic signed [WORD_W-1:0] r2_vel, r2_pos;
    t_ctrl                    r2_ctrl;
    // Stage 3: signed position step.
    logic [WORD_W:0]          c_mag3;
    logic signed [WORD_W:0]   n_dp;
    logic signed [WORD_W:0]   r3_dp;
    logic signed [WORD_W-1:0] r3_vel, r3_pos;
    t_ctrl                    r3_ctrl;
    // Stage 4: sum and saturate.
    logic signed [WORD_W+1:0] c_sum;
    logic signed [WORD_W-1:0] n_pn;
    logic                     n_sat;
    logic signed [WORD_W-1:0] r4_vel, r4_pos;
    t_ctrl                    r4_ctrl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= i_vel[WORD_W-1] ? WORD_W'(-i_vel) : WORD_W'(i_vel);
            r1_neg  <= i_vel[WORD_W-1];
            r1_vel  <= i_vel;
            r1_pos  <= i_pos;
            r1_ctrl <= i_ctrl;

            r2_prod <= PROD_W'(r1_mag) * PROD_W'(i_dt);
            r2_neg  <= r1_neg;
            r2_vel  <= r1_vel;
            r2_pos  <= r1_pos;
            r2_ctrl <= r1_ctrl;

            r3_dp   <= n_dp;
            r3_vel  <= r2_vel;
            r3_pos  <= r2_pos;
            r3_ctrl <= r2_ctrl;

            r4_vel        <= r3_vel;
            r4_pos        <= n_pn;
            r4_ctrl.sat   <= r3_ctrl.sat | n_sat;
            r4_ctrl.mzero <= r3_ctrl.mzero;
        end
    end

    always_comb begin
        c_mag3 = {1'b0, r2_prod[FRAC_W+WORD_W-1:FRAC_W]};
        n_dp   = r2_neg ? -$signed(c_mag3) : $signed(c_mag3);
    end

    always_comb begin
        c_sum = {{2{r3_pos[WORD_W-1]}}, r3_pos} + {r3_dp[WORD_W], r3_dp};
        n_sat = 1'b0;
        if (c_sum > HI) begin
            n_pn  = HI[WORD_W-1:0];
            n_sat = 1'b1;
        end else if (c_sum < LO) begin
            n_pn  = LO[WORD_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_pn = c_sum[WORD_W-1:0];
        end
    end

    assign o_vel  = r4_vel;
    assign o_pos  = r4_pos;
    assign o_ctrl = r4_ctrl;

endmodule

@@ design/particle_euler_integrator.sv @@
// Throughput: one particle per cycle while not stalled; the divider is fully pipelined, one quotient bit per stage.
// A stall at the output freezes the whole pipeline, so the input is ready whenever the
// output register is empty or being taken.
// Reset (synchronous, active low) clears all valid bits and sets the step to 655.
// ---------------------------------------------------------------------------
// particle_euler_integrator
// Semi-implicit Euler step for one particle per transfer on three axes.
// ---------------------------------------------------------------------------
module particle_euler_integrator
    import peul_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [FRAC_BITS:0]          i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_force_x,
    input  logic signed [WORD_BITS-1:0] i_force_y,
    input  logic signed [WORD_BITS-1:0] i_force_z,
    input  logic [WORD_BITS-1:0]        i_mass,
    input  logic signed [WORD_BITS-1:0] i_vel_in_x,
    input  logic signed [WORD_BITS-1:0] i_vel_in_y,
    input  logic signed [WORD_BITS-1:0] i_vel_in_z,
    input  logic signed [WORD_BITS-1:0] i_pos_in_x,
    input  logic signed [WORD_BITS-1:0] i_pos_in_y,
    input  logic signed [WORD_BITS-1:0] i_pos_in_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_vel_out_x,
    output logic signed [WORD_BITS-1:0] o_vel_out_y,
    output logic signed [WORD_BITS-1:0] o_vel_out_z,
    output logic signed [WORD_BITS-1:0] o_pos_out_x,
    output logic signed [WORD_BITS-1:0] o_pos_out_y,
    output logic signed [WORD_BITS-1:0] o_pos_out_z,
    output logic [1:0]                  o_status
);

    // The dividend is |force| * step, which is WORD_BITS + FRAC_BITS + 1 bits wide.
    localparam int DT_W   = FRAC_BITS + 1;
    localparam int PROD_W = WORD_BITS + DT_W;
    localparam int SIDE_W = 2 * WORD_BITS + 2;
    // Two entry stages, the divider, two velocity stages and four position stages.
    localparam int LAT    = 2 + PROD_W + 2 + 4;
    localparam logic [DT_W-1:0] DT_ONE = DT_W'(1) << FRAC_BITS;

    // The step register. Writes must only happen while the pipeline is empty; the block does not enforce it.
    logic [DT_W-1:0] r_time_step;
    logic [DT_W-1:0] c_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= DT_W'(DT_RESET);
        end else if (i_cfg_we) begin
            r_time_step <= i_cfg_data;
        end
    end

    // A step above 1.0 counts as exactly 1.0.
    assign c_dt = (r_time_step > DT_ONE) ? DT_ONE : r_time_step;

    // One enable for every stage: everything moves unless a finished result
    // sits in the output register and the consumer is not taking it.
    logic en;
    logic [LAT-1:0] r_vld;

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Mass is shared by all axes.
    logic [WORD_BITS-1:0] r1_mass, r2_mass;
    logic                 r1_mzero, r2_mzero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_mass  <= i_mass;
            r1_mzero <= (i_mass == '0);
            r2_mass  <= r1_mass;
            r2_mzero <= r1_mzero;
        end
    end

    logic signed [WORD_BITS-1:0] c_force [3];
    logic signed [WORD_BITS-1:0] c_vin   [3];
    logic signed [WORD_BITS-1:0] c_pin   [3];
    logic signed [WORD_BITS-1:0] c_vout  [3];
    logic signed [WORD_BITS-1:0] c_pout  [3];
    t_ctrl                       c_ctrl  [3];

    assign c_force[0] = i_force_x;
    assign c_force[1] = i_force_y;
    assign c_force[2] = i_force_z;
    assign c_vin[0]   = i_vel_in_x;
    assign c_vin[1]   = i_vel_in_y;
    assign c_vin[2]   = i_vel_in_z;
    assign c_pin[0]   = i_pos_in_x;
    assign c_pin[1]   = i_pos_in_y;
    assign c_pin[2]   = i_pos_in_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [WORD_BITS-1:0]        r1_fabs;
        logic                        r1_fneg;
        logic signed [WORD_BITS-1:0] r1_vel, r1_pos;
        logic [PROD_W-1:0]           r2_prod;
        logic                        r2_fneg;
        logic signed [WORD_BITS-1:0] r2_vel, r2_pos;
        logic [PROD_W-1:0]           c_quo;
        logic [SIDE_W-1:0]           c_side;
        logic signed [WORD_BITS-1:0] c_vn, c_pv;
        t_ctrl                       c_vctrl;

        // Stage 1 takes the force magnitude, stage 2 multiplies by the step.
        always_ff @(posedge i_clk) begin
            if (en) begin
                r1_fabs <= c_force[a][WORD_BITS-1] ? WORD_BITS'(-c_force[a])
                                                   : WORD_BITS'(c_force[a]);
                r1_fneg <= c_force[a][WORD_BITS-1];
                r1_vel  <= c_vin[a];
                r1_pos  <= c_pin[a];
                r2_prod <= PROD_W'(r1_fabs) * PROD_W'(c_dt);
                r2_fneg <= r1_fneg;
                r2_vel  <= r1_vel;
                r2_pos  <= r1_pos;
            end
        end

        peul_div #(
            .NUM_W  (PROD_W),
            .DEN_W  (WORD_BITS),
            .SIDE_W (SIDE_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r2_prod),
            .i_den  (r2_mass),
            .i_side ({r2_mzero, r2_fneg, r2_vel, r2_pos}),
            .o_quo  (c_quo),
            .o_side (c_side)
        );

        peul_vel #(
            .WORD_W (WORD_BITS),
            .QUO_W  (PROD_W)
        ) u_vel (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_quo   (c_quo),
            .i_fneg  (c_side[SIDE_W-2]),
            .i_mzero (c_side[SIDE_W-1]),
            .i_vel   (c_side[2*WORD_BITS-1:WORD_BITS]),
            .i_pos   (c_side[WORD_BITS-1:0]),
            .o_vel   (c_vn),
            .o_pos   (c_pv),
            .o_ctrl  (c_vctrl)
        );

        // The last stage of the position unit is the output register.
        peul_pos #(
            .WORD_W (WORD_BITS),
            .FRAC_W (FRAC_BITS)
        ) u_pos (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_dt   (c_dt),
            .i_vel  (c_vn),
            .i_pos  (c_pv),
            .i_ctrl (c_vctrl),
            .o_vel  (c_vout[a]),
            .o_pos  (c_pout[a]),
            .o_ctrl (c_ctrl[a])
        );
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_vel_out_x = c_vout[0];
    assign o_vel_out_y = c_vout[1];
    assign o_vel_out_z = c_vout[2];
    assign o_pos_out_x = c_pout[0];
    assign o_pos_out_y = c_pout[1];
    assign o_pos_out_z = c_pout[2];

    // Saturation on any axis outranks the zero mass code.
    always_comb begin
        if (c_ctrl[0].sat || c_ctrl[1].sat || c_ctrl[2].sat) begin
            o_status = ST_SAT;
        end else if (c_ctrl[0].mzero) begin
            o_status = ST_ZMASS;
        end else begin
            o_status = ST_OK;
        end
    end

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pos_out_x) && $stable(o_vel_out_z)
            && $stable(o_status))
        else $error("result changed while stalled");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_ZMASS || o_status == ST_SAT))
        else $error("undefined status code");

    a_mzero_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (c_ctrl[0].mzero == c_ctrl[1].mzero && c_ctrl[1].mzero == c_ctrl[2].mzero))
        else $error("axes disagree on zero mass");
`endif

endmodule
